>>> rtl/clt_pkg.sv
// Package for the command line tokenizer: item and result structs,
// codes and size constants. No dependencies.
package clt_pkg;

  localparam int TOKEN_LIMIT = 40;
  localparam int PARAM_LIMIT = 20;

  localparam logic [4:0] PARAM_CAP_RESET  = 5'd20;
  localparam logic [7:0] CHAR_SPACE       = 8'h20;
  localparam logic [7:0] CHAR_LOWER_A     = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z     = 8'h7a;
  localparam logic [7:0] CASE_OFFSET      = 8'h20;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [4:0] SLOT_PIN     = 5'd0;
  localparam logic [4:0] SLOT_COMMAND = 5'd1;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_PIN = 2'd1,
    STATUS_NO_CMD = 2'd2
  } status_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] token_slot;
    logic [5:0] char_pos;
    logic [7:0] char_out;
    status_t    status;
    logic [4:0] param_count;
    logic       overflow;
  } result_t;

endpackage

>>> rtl/command_line_tokenizer_core.sv
// Top level of the command line tokenizer: item channel, result channel,
// parameter cap write port. Uses clt_pkg, clt_tokenizer and clt_out_fifo.
//
// Usage:
//   item channel (item_valid / item_stall / item) carries one message byte
//   per transaction (mode 0) or an end-of-message marker (mode 1).
//   result channel (result_valid / result_stall / result) carries one token
//   character per kept byte and one summary per end-of-message marker.
//   Skipped bytes, the terminating space and refused overflow bytes make no
//   result transaction.
//   cfg_we / cfg_data write the parameter cap; write only while idle.
// Timing:
//   One item per cycle sustained while result_stall stays low. A result is
//   written into the result queue when its item is accepted and is presented
//   on result_valid from there. The rate is set by the update of the message
//   state registers in clt_tokenizer, which each byte reads and writes.
// Stall:
//   Results wait in a two-entry queue; item_stall rises only while both
//   entries are held, so one pending result never blocks the next item.
// Reset:
//   rst (synchronous) empties the queue, clears the message state and loads
//   the parameter cap with 20.
module command_line_tokenizer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  clt_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output clt_pkg::result_t result
);

  logic             accept;
  logic             step_valid;
  clt_pkg::result_t step_result;
  logic             full;

  // hold items while the result queue is full
  assign item_stall = full;
  assign accept     = item_valid && !item_stall;

  clt_tokenizer u_tokenizer (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .item        (item),
    .step_valid  (step_valid),
    .step_result (step_result)
  );

  // push only results of accepted transactions
  clt_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (accept && step_valid),
    .push_data    (step_result),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/clt_tokenizer.sv
// Tokenizer state and per-byte update: message state registers, the
// parameter cap register and the result of each accepted item. Uses clt_pkg.
module clt_tokenizer (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_data,
  input  logic             accept,
  input  clt_pkg::item_t   item,
  output logic             step_valid,
  output clt_pkg::result_t step_result
);

  logic       in_token, in_token_next;
  logic [5:0] token_length, token_length_next;
  logic [4:0] tokens_seen, tokens_seen_next;
  logic       overflowed, overflowed_next;
  logic [4:0] param_cap;

  logic [4:0] limit;
  logic       emit;
  logic [4:0] emit_slot;
  logic [5:0] emit_pos;
  logic [5:0] pos_inc;
  logic [7:0] emit_char;

  assign limit = (param_cap > 5'(clt_pkg::PARAM_LIMIT)) ?
                 5'(clt_pkg::PARAM_LIMIT) : param_cap;

  always_comb begin
    in_token_next     = in_token;
    token_length_next = token_length;
    tokens_seen_next  = tokens_seen;
    overflowed_next   = overflowed;
    emit              = 1'b0;
    emit_slot         = tokens_seen - 5'd1;
    emit_pos          = token_length;
    step_valid        = 1'b0;
    step_result       = '0;

    if (item.mode == clt_pkg::MODE_END) begin
      step_valid       = 1'b1;
      step_result.kind = clt_pkg::KIND_SUMMARY;
      if (tokens_seen == 5'd0) begin
        step_result.status = clt_pkg::STATUS_NO_PIN;
      end else if (tokens_seen == 5'd1) begin
        step_result.status = clt_pkg::STATUS_NO_CMD;
      end else begin
        step_result.status      = clt_pkg::STATUS_OK;
        step_result.param_count = tokens_seen - 5'd2;
        step_result.overflow    = overflowed;
      end
      in_token_next     = 1'b0;
      token_length_next = '0;
      tokens_seen_next  = '0;
      overflowed_next   = 1'b0;
    end else if (!overflowed) begin
      if (in_token) begin
        if (item.char_code == clt_pkg::CHAR_SPACE) begin
          in_token_next     = 1'b0;
          token_length_next = '0;
        end else begin
          emit = 1'b1;
        end
      end else if (item.char_code > clt_pkg::CHAR_SPACE && !item.char_code[7]) begin
        if (tokens_seen >= limit + 5'd2) begin
          overflowed_next = 1'b1;
        end else begin
          tokens_seen_next = tokens_seen + 5'd1;
          emit_slot        = tokens_seen;
          emit_pos         = '0;
          emit             = 1'b1;
        end
      end
    end

    pos_inc = emit_pos + 6'd1;

    emit_char = item.char_code;
    if (emit_slot == clt_pkg::SLOT_COMMAND && item.char_code >= clt_pkg::CHAR_LOWER_A &&
        item.char_code <= clt_pkg::CHAR_LOWER_Z) begin
      emit_char = item.char_code - clt_pkg::CASE_OFFSET;
    end

    if (emit) begin
      step_valid             = 1'b1;
      step_result.kind       = clt_pkg::KIND_CHAR;
      step_result.token_slot = emit_slot;
      step_result.char_pos   = emit_pos;
      step_result.char_out   = emit_char;
      // end the token when it hits the length limit
      if (pos_inc >= 6'(clt_pkg::TOKEN_LIMIT)) begin
        in_token_next     = 1'b0;
        token_length_next = '0;
      end else begin
        in_token_next     = 1'b1;
        token_length_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token     <= 1'b0;
      token_length <= '0;
      tokens_seen  <= '0;
      overflowed   <= 1'b0;
      param_cap    <= clt_pkg::PARAM_CAP_RESET;
    end else begin
      if (accept) begin
        in_token     <= in_token_next;
        token_length <= token_length_next;
        tokens_seen  <= tokens_seen_next;
        overflowed   <= overflowed_next;
      end
      if (cfg_we) begin
        param_cap <= cfg_data;
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    token_length < 6'(clt_pkg::TOKEN_LIMIT))
    else $error("token length past limit");
  a_len_idle: assert property (@(posedge clk) disable iff (rst)
    !in_token |-> token_length == 6'd0)
    else $error("token length nonzero outside a token");
  a_token_counted: assert property (@(posedge clk) disable iff (rst)
    in_token |-> tokens_seen != 5'd0)
    else $error("inside a token with no token counted");
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    tokens_seen <= 5'(clt_pkg::PARAM_LIMIT + 2))
    else $error("token count past slot range");

endmodule

>>> rtl/clt_out_fifo.sv
// Two-entry result queue between the tokenizer and the result channel.
// Uses clt_pkg.
module clt_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clt_pkg::result_t push_data,
  output logic             full,
  output logic             result_valid,
  input  logic             result_stall,
  output clt_pkg::result_t result
);

  clt_pkg::result_t entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       pop;

  assign pop          = result_valid && !result_stall;
  assign full         = count == 2'd2;
  assign result_valid = count != 2'd0;
  assign result       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wptr == rptr)
    else $error("queue pointers disagree with count");

endmodule
